// ===== rtl/core/rational_arith_unit_assert.svh =====
// Assertion macros used by the rational arithmetic unit top level.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
// Property check, disabled while in reset.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle check, disabled while in reset.
`define RAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ===== rtl/core/rau_pkg.sv =====
// Types and constants of the rational arithmetic unit.
package rau_pkg;
  localparam int VAL_W = 64;
  localparam int CNT_W = 6;
  localparam int FIELD_W = 32;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_CMP  = 3'd3,
    CMD_NORM = 3'd4
  } cmd_t;

  localparam logic [1:0] ORD_EQ   = 2'b00;
  localparam logic [1:0] ORD_GT   = 2'b01;
  localparam logic [1:0] ORD_LT   = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_EVAL,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } st_t;
endpackage

// ===== rtl/core/rau_mul.sv =====
// Registered signed multiplier shared by all product steps.
module rau_mul #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   x,
  input  logic signed [W-1:0]   y,
  output logic signed [2*W-1:0] prod
);
  logic signed [2*W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= x * y;
  end

  assign prod = prod_r;
endmodule

// ===== rtl/core/rau_gcd.sv =====
// Binary gcd unit: one shift or subtract-and-shift step per cycle.
module rau_gcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rau_pkg::VAL_W-1:0] a,
  input  logic [rau_pkg::VAL_W-1:0] b,
  output logic                      done,
  output logic [rau_pkg::VAL_W-1:0] g
);
  logic [rau_pkg::VAL_W-1:0] u_r, v_r, g_r, diff;
  logic [rau_pkg::CNT_W-1:0] k_r;
  logic                      twos_r, busy_r, done_r;

  assign diff = (u_r > v_r) ? (u_r - v_r) : (v_r - u_r);

  always_ff @(posedge clk) begin
    if (start) begin
      u_r <= a;
      v_r <= b;
      k_r <= '0;
    end else if (busy_r) begin
      if (twos_r) begin
        if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end
      end else if (u_r == v_r) begin
        g_r <= u_r << k_r;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r > v_r) begin
        u_r <= diff >> 1;
      end else begin
        v_r <= diff >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      twos_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        twos_r <= 1'b1;
      end else if (busy_r) begin
        if (twos_r) begin
          if (u_r[0] || v_r[0]) begin
            twos_r <= 1'b0;
          end
        end else if (u_r == v_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;
endmodule

// ===== rtl/core/rau_div.sv =====
// Restoring divider: one quotient bit per cycle.
module rau_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rau_pkg::VAL_W-1:0] dividend,
  input  logic [rau_pkg::VAL_W-1:0] divisor,
  output logic                      done,
  output logic [rau_pkg::VAL_W-1:0] quo
);
  logic [rau_pkg::VAL_W-1:0] rem_r, quo_r, dvs_r, rem_sh, rem_nxt, quo_nxt;
  logic [rau_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r, done_r, ge;

  assign rem_sh  = {rem_r[rau_pkg::VAL_W-2:0], quo_r[rau_pkg::VAL_W-1]};
  assign ge      = (rem_sh >= dvs_r);
  assign rem_nxt = ge ? (rem_sh - dvs_r) : rem_sh;
  assign quo_nxt = {quo_r[rau_pkg::VAL_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {rau_pkg::CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== rtl/core/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, operand and result registers.
//
//  channel | dir | beat contents
//  in_*    | in  | cmd, a_num, a_den, b_num, b_den
//  out_*   | out | res_num, res_den, valid_res, is_integer, order
//
// An unused command goes from idle straight to the done state. Every other command
// runs the product steps; compare or a zero operand then goes to done, and arithmetic
// runs binary gcd steps and then two restoring divisions, numerator then denominator.
// in_tready is high only while idle. A stalled result holds in the output register
// and the sequencer waits in its done state until the register frees up.
// Reset is synchronous, active low, and clears the sequencer and out_tvalid.
`include "rational_arith_unit_assert.svh"
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero pad
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_num[63:0], res_den[126:64], valid_res[127], is_integer[128],
  // order[130:129], zero pad
  output logic [135:0] out_tdata
);
  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int VW = rau_pkg::VAL_W;
  localparam int FW = rau_pkg::FIELD_W;

  rau_pkg::st_t state_r, state_nxt;

  logic [2:0]          cmd_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [W-1:0] an_s, ad_s, bn_s, bd_s;
  logic signed [W-1:0] xa, xad, xb, xbd, mx, my;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] p0_r, p1_r, p2_r, prod_x, num_w, den_w;
  logic [VW-1:0]        mn_w, md_w, mn_r, md_r, gcd_g, div_q, div_a, div_b;
  logic                 neg_r, gcd_start, gcd_done, div_start, div_done;
  logic                 is_cmp, path_ok;
  logic signed [VW-1:0] res_num_r;
  logic [VW-2:0]        res_den_r;
  logic                 valid_r, int_r, load_out;
  logic [1:0]           order_r;
  logic [135:0]         out_tdata_r;
  logic                 out_tvalid_r;
  logic                 st_gcd, st_div, out_is_int, out_den_one;

  // Take the low operand bits and saturate the most negative value.
  function automatic logic signed [W-1:0] take(input logic [FW-1:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    if (v == {1'b1, {(W-1){1'b0}}}) begin
      v = v + 1'b1;
    end
    return $signed(v);
  endfunction

  assign an_s = take(in_tdata[34:3]);
  assign ad_s = take(in_tdata[66:35]);
  assign bn_s = take(in_tdata[98:67]);
  assign bd_s = take(in_tdata[130:99]);

  // Compare flips each fraction so its denominator is positive.
  assign is_cmp = (cmd_r == rau_pkg::CMD_CMP);
  assign xa  = (is_cmp && ad_r < 0) ? -an_r : an_r;
  assign xad = (is_cmp && ad_r < 0) ? -ad_r : ad_r;
  assign xb  = (is_cmp && bd_r < 0) ? -bn_r : bn_r;
  assign xbd = (is_cmp && bd_r < 0) ? -bd_r : bd_r;

  always_comb begin
    unique case (state_r)
      rau_pkg::ST_MUL0: begin
        mx = xa;
        my = (cmd_r == rau_pkg::CMD_MUL) ? bn_r : xbd;
      end
      rau_pkg::ST_MUL1: begin
        mx = xb;
        my = xad;
      end
      default: begin
        mx = ad_r;
        my = bd_r;
      end
    endcase
  end

  rau_mul #(.W(W)) u_mul (
    .clk  (clk),
    .x    (mx),
    .y    (my),
    .prod (prod)
  );

  assign prod_x = VW'(prod);

  // Form the unreduced fraction.
  always_comb begin
    case (cmd_r)
      rau_pkg::CMD_ADD: begin
        num_w = p0_r + p1_r;
        den_w = p2_r;
      end
      rau_pkg::CMD_SUB: begin
        num_w = p0_r - p1_r;
        den_w = p2_r;
      end
      rau_pkg::CMD_MUL: begin
        num_w = p0_r;
        den_w = p2_r;
      end
      default: begin
        num_w = {{(VW-W){an_r[W-1]}}, an_r};
        den_w = {{(VW-W){ad_r[W-1]}}, ad_r};
      end
    endcase
  end

  assign mn_w    = (num_w < 0) ? VW'(-num_w) : VW'(num_w);
  assign md_w    = (den_w < 0) ? VW'(-den_w) : VW'(den_w);
  assign path_ok = !is_cmp && (den_w != '0) && (num_w != '0);

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a     (mn_w),
    .b     (md_w),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  assign div_a = (state_r == rau_pkg::ST_GCD) ? mn_r : md_r;
  assign div_b = gcd_g;

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q)
  );

  assign load_out = (state_r == rau_pkg::ST_DONE) && (!out_tvalid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[2:0] <= rau_pkg::CMD_NORM) begin
            state_nxt = rau_pkg::ST_MUL0;
          end else begin
            state_nxt = rau_pkg::ST_DONE;
          end
        end
      end
      rau_pkg::ST_MUL0:    state_nxt = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1:    state_nxt = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2:    state_nxt = rau_pkg::ST_MUL3;
      rau_pkg::ST_MUL3:    state_nxt = rau_pkg::ST_EVAL;
      rau_pkg::ST_EVAL:    state_nxt = path_ok ? rau_pkg::ST_GCD : rau_pkg::ST_DONE;
      rau_pkg::ST_GCD: begin
        if (gcd_done) begin
          state_nxt = rau_pkg::ST_DIV_NUM;
        end
      end
      rau_pkg::ST_DIV_NUM: begin
        if (div_done) begin
          state_nxt = rau_pkg::ST_DIV_DEN;
        end
      end
      rau_pkg::ST_DIV_DEN: begin
        if (div_done) begin
          state_nxt = rau_pkg::ST_DONE;
        end
      end
      rau_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = rau_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rau_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready = (state_r == rau_pkg::ST_IDLE);
    gcd_start = (state_r == rau_pkg::ST_EVAL) && path_ok;
    div_start = ((state_r == rau_pkg::ST_GCD) && gcd_done) ||
                ((state_r == rau_pkg::ST_DIV_NUM) && div_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::ST_IDLE: begin
        cmd_r     <= in_tdata[2:0];
        an_r      <= an_s;
        ad_r      <= ad_s;
        bn_r      <= bn_s;
        bd_r      <= bd_s;
        res_num_r <= '0;
        res_den_r <= '0;
        valid_r   <= 1'b0;
        int_r     <= 1'b0;
        order_r   <= rau_pkg::ORD_EQ;
      end
      rau_pkg::ST_MUL1: p0_r <= prod_x;
      rau_pkg::ST_MUL2: p1_r <= prod_x;
      rau_pkg::ST_MUL3: p2_r <= prod_x;
      rau_pkg::ST_EVAL: begin
        mn_r  <= mn_w;
        md_r  <= md_w;
        neg_r <= (num_w < 0) != (den_w < 0);
        if (is_cmp) begin
          // Drop the compare when either denominator is zero.
          if (ad_r != '0 && bd_r != '0) begin
            valid_r <= 1'b1;
            if (p0_r < p1_r) begin
              order_r <= rau_pkg::ORD_LT;
            end else if (p0_r > p1_r) begin
              order_r <= rau_pkg::ORD_GT;
            end
          end
        end else if (den_w != '0 && num_w == '0) begin
          res_den_r <= (VW-1)'(1);
          valid_r   <= 1'b1;
          int_r     <= 1'b1;
        end
      end
      rau_pkg::ST_DIV_NUM: begin
        if (div_done) begin
          res_num_r <= neg_r ? -$signed(div_q) : $signed(div_q);
        end
      end
      rau_pkg::ST_DIV_DEN: begin
        if (div_done) begin
          res_den_r <= div_q[VW-2:0];
          valid_r   <= 1'b1;
          int_r     <= (div_q == VW'(1));
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the beat until it is taken.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {5'd0, order_r, int_r, valid_r, res_den_r, res_num_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign st_gcd      = (state_r == rau_pkg::ST_GCD);
  assign st_div      = (state_r == rau_pkg::ST_DIV_NUM) || (state_r == rau_pkg::ST_DIV_DEN);
  assign out_is_int  = out_tvalid_r && out_tdata_r[128];
  assign out_den_one = out_tdata_r[127] && (out_tdata_r[126:64] == 63'd1);

  `RAU_ASSERT(a_gcd_done_state, gcd_done |-> st_gcd, "gcd done outside gcd state")
  `RAU_ASSERT(a_div_done_state, div_done |-> st_div, "divider done outside divide states")
  `RAU_ASSERT_NEXT(a_load_valid, load_out, out_tvalid_r, "loaded result not presented")
  `RAU_ASSERT(a_int_den_one, out_is_int |-> out_den_one, "integer flag without unit denominator")
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the rational arithmetic unit.
module tb_top;
  localparam int WDOG_LIMIT = 20000;

  // Members listed from the highest bits down, so the last member, cmd, lands lowest.
  typedef struct packed {
    logic [31:0] b_den;
    logic [31:0] b_num;
    logic [31:0] a_den;
    logic [31:0] a_num;
    logic [2:0]  cmd;
  } frac_op_t;

  typedef struct packed {
    logic [1:0]  order;
    logic        is_integer;
    logic        valid_res;
    logic [62:0] res_den;
    logic [63:0] res_num;
  } frac_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;

  frac_op_t  op_q[$];
  frac_res_t expected_q[$];
  int        err_cnt;
  int        idle_cnt;
  int        send_idle_pct;
  int        recv_idle_pct;

  rational_arith_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Read an operand as 32-bit two's complement, saturating the minimum.
  function automatic longint sat_operand(logic [31:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v == -64'sd2147483648) v = -64'sd2147483647;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // Reduce num/den to lowest terms with the sign on the numerator.
  function automatic frac_res_t reduce_frac(longint num, longint den);
    frac_res_t r;
    longint unsigned mn, md, x, y, t;
    r = '0;
    if (den == 0) return r;
    r.valid_res = 1'b1;
    if (num == 0) begin
      r.res_den = 63'd1;
      r.is_integer = 1'b1;
      return r;
    end
    mn = abs64(num);
    md = abs64(den);
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 1;
    mn = mn / x;
    md = md / x;
    r.res_num = ((num < 0) != (den < 0)) ? -mn : mn;
    r.res_den = md[62:0];
    r.is_integer = (md == 1);
    return r;
  endfunction

  function automatic frac_res_t predict_frac(frac_op_t op);
    frac_res_t r;
    longint an, ad, bn, bd, l, rt;
    an = sat_operand(op.a_num);
    ad = sat_operand(op.a_den);
    bn = sat_operand(op.b_num);
    bd = sat_operand(op.b_den);
    r = '0;
    case (op.cmd)
      rau_pkg::CMD_ADD:  r = reduce_frac(an * bd + bn * ad, ad * bd);
      rau_pkg::CMD_SUB:  r = reduce_frac(an * bd - bn * ad, ad * bd);
      rau_pkg::CMD_MUL:  r = reduce_frac(an * bn, ad * bd);
      rau_pkg::CMD_NORM: r = reduce_frac(an, ad);
      rau_pkg::CMD_CMP: begin
        if (ad != 0 && bd != 0) begin
          if (ad < 0) begin an = -an; ad = -ad; end
          if (bd < 0) begin bn = -bn; bd = -bd; end
          l = an * bd;
          rt = bn * ad;
          r.valid_res = 1'b1;
          r.order = (l < rt) ? rau_pkg::ORD_LT :
                    ((l > rt) ? rau_pkg::ORD_GT : rau_pkg::ORD_EQ);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 20)) - 10);
      1: return 32'h8000_0000 + 32'($urandom_range(0, 1));
      2: return 32'h7fff_ffff - 32'($urandom_range(0, 1));
      3: return 32'($urandom_range(0, 1000)) * 32'($urandom_range(1, 60));
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                        logic [31:0] bn, logic [31:0] bd);
    frac_op_t op;
    op.cmd = c;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    op_q = {op_q, op};
  endtask

  // Driver: present the head of the pending queue, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) void'(op_q.pop_front());
      if (op_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {5'd0, op_q[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict on each accepted input beat.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_q = {expected_q, predict_frac(frac_op_t'(in_tdata[130:0]))};
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk) begin
    frac_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = frac_res_t'(out_tdata[130:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", got.res_num, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.res_num !== want.res_num)
            report_mismatch("res_num", got.res_num, want.res_num);
          if (got.res_den !== want.res_den)
            report_mismatch("res_den", 64'(got.res_den), 64'(want.res_den));
          if (got.valid_res !== want.valid_res)
            report_mismatch("valid_res", 64'(got.valid_res), 64'(want.valid_res));
          if (got.is_integer !== want.is_integer)
            report_mismatch("is_integer", 64'(got.is_integer), 64'(want.is_integer));
          if (got.order !== want.order)
            report_mismatch("order", 64'(got.order), 64'(want.order));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int k, phase;
    err_cnt = 0;
    send_idle_pct = 33;
    recv_idle_pct = 58;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every command, extremes, zero cases, unused codes.
    add_op(rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    add_op(rau_pkg::CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    add_op(rau_pkg::CMD_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001);
    add_op(rau_pkg::CMD_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    add_op(rau_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    add_op(rau_pkg::CMD_NORM, 32'd6, 32'hffff_fffc, 32'd9, 32'd0);
    add_op(rau_pkg::CMD_NORM, 32'd0, 32'hffff_fff9, 32'd0, 32'd0);
    add_op(rau_pkg::CMD_NORM, 32'd5, 32'd0, 32'd1, 32'd1);
    add_op(rau_pkg::CMD_ADD, 32'd3, 32'd0, 32'd1, 32'd1);
    add_op(rau_pkg::CMD_MUL, 32'd0, 32'd5, 32'd7, 32'd3);
    add_op(rau_pkg::CMD_NORM, 32'hffff_fff6, 32'd5, 32'd0, 32'd0);
    add_op(rau_pkg::CMD_CMP, 32'd1, 32'hffff_fffe, 32'd1, 32'd2);
    add_op(rau_pkg::CMD_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    add_op(rau_pkg::CMD_CMP, 32'd3, 32'd2, 32'd1, 32'hffff_ffff);
    add_op(rau_pkg::CMD_CMP, 32'd1, 32'd0, 32'd1, 32'd1);
    add_op(rau_pkg::CMD_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(3'd5, 32'd1, 32'd1, 32'd1, 32'd1);
    add_op(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_op(3'd7, 32'd2, 32'd3, 32'd4, 32'd5);

    // Random, in three phases with differing idle rates.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 33 : 0;
      for (k = 0; k < 150; k++)
        add_op(3'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 7)
                                               : $urandom_range(0, 4)),
               rand_operand(), rand_operand(), rand_operand(), rand_operand());
      wait (op_q.size() == 0);
    end
    @(posedge clk);
    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
